// ===== design/analog_keypad_debounce_repeat_core_defines.svh =====
// ----------------------------------------------------------------------------
// keypad decoder assertion macros
// shared concurrent assertion forms for the keypad decoder
// ----------------------------------------------------------------------------
`ifndef ANALOG_KEYPAD_DEBOUNCE_REPEAT_CORE_DEFINES_SVH
`define ANALOG_KEYPAD_DEBOUNCE_REPEAT_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define AKDR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define AKDR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/akdr_pkg.sv =====
// ----------------------------------------------------------------------------
// keypad decoder package
// word types, key codes and ladder window classification
// ----------------------------------------------------------------------------
package akdr_pkg;

    typedef struct packed {
        logic [9:0] sample;
        logic       arm_repeat;
    } in_word_t;

    typedef struct packed {
        logic [2:0] key_code;
        logic       key_hit;
    } out_word_t;

    localparam logic [2:0] KEY_NONE          = 3'd0;
    localparam logic [2:0] KEY_BRIGHT_DOWN   = 3'd1;
    localparam logic [2:0] KEY_BRIGHT_UP     = 3'd2;
    localparam logic [2:0] KEY_CONTRAST_UP   = 3'd3;
    localparam logic [2:0] KEY_CONTRAST_DOWN = 3'd4;
    localparam logic [2:0] KEY_MODE          = 3'd5;

    localparam logic [7:0] HOLD_RELOAD_RESET = 8'd255;
    localparam logic [7:0] HOLD_COUNT_RESET  = 8'd255;

    // open window bounds on the ladder reading
    localparam logic [9:0] WIN1_HI = 10'h030;
    localparam logic [9:0] WIN2_LO = 10'h0a0;
    localparam logic [9:0] WIN2_HI = 10'h120;
    localparam logic [9:0] WIN3_LO = 10'h1f0;
    localparam logic [9:0] WIN3_HI = 10'h230;
    localparam logic [9:0] WIN4_LO = 10'h2d0;
    localparam logic [9:0] WIN4_HI = 10'h320;
    localparam logic [9:0] WIN5_LO = 10'h350;
    localparam logic [9:0] WIN5_HI = 10'h380;

    function automatic logic [2:0] classify(input logic [9:0] s);
        logic [2:0] code;
        code = KEY_NONE;
        if (s < WIN1_HI)
            code = KEY_BRIGHT_DOWN;
        else if (s > WIN2_LO && s < WIN2_HI)
            code = KEY_BRIGHT_UP;
        else if (s > WIN3_LO && s < WIN3_HI)
            code = KEY_CONTRAST_UP;
        else if (s > WIN4_LO && s < WIN4_HI)
            code = KEY_CONTRAST_DOWN;
        else if (s > WIN5_LO && s < WIN5_HI)
            code = KEY_MODE;
        return code;
    endfunction

endpackage

// ===== design/analog_keypad_debounce_repeat_core.sv =====
// ----------------------------------------------------------------------------
// resistor ladder keypad decoder with debounce and auto-repeat
// one adc sample word in, one key word out, while not stalled one word per cycle
// ----------------------------------------------------------------------------
// usage:
//   sample channel (sample_valid / sample_stall / sample_word) carries one
//   10-bit ladder reading plus an arm_repeat flag per word
//   key channel (key_valid / key_stall / key_word) returns one word per
//   sample: the reported key code and a hit pulse flag
//   cfg_write / cfg_data load hold_reload, the countdown before repeat
// timing:
//   an accepted sample passes the input register, then classify and debounce
//   logic into the result register, before it shows on key_valid
//   throughput is one word per cycle while key_stall is low; the debounce
//   state loads with the result register, so back to back samples chain
// reset:
//   all state clears to no key, hold count and reload to 255, not armed
// stall:
//   a stalled key word holds in the result register; the input register
//   still takes a new sample, and sample_stall rises only when both hold
//   words
// ----------------------------------------------------------------------------
`include "analog_keypad_debounce_repeat_core_defines.svh"

module analog_keypad_debounce_repeat_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  akdr_pkg::in_word_t  sample_word,
    output logic                key_valid,
    input  logic                key_stall,
    output akdr_pkg::out_word_t key_word,
    input  logic                cfg_write,
    input  logic [7:0]          cfg_data
);

    // configuration
    logic [7:0] hold_reload_reg;

    // input register
    logic               in_valid_reg;
    akdr_pkg::in_word_t in_word_reg;

    // debounce state
    logic [2:0] prev_code_reg, prev_code_next;
    logic [2:0] accepted_code_reg, accepted_code_next;
    logic [7:0] hold_count_reg, hold_count_next;
    logic       armed_reg, armed_next;

    // result register, also holds the reported code and hit flag state
    logic                out_valid_reg;
    akdr_pkg::out_word_t out_word_reg, out_word_next;

    logic       out_free;
    logic       process;
    logic       new_key;
    logic [2:0] code;
    logic       armed_now;

    // result register can take a word when empty or being drained
    assign out_free     = !out_valid_reg || !key_stall;
    assign process      = in_valid_reg && out_free;
    assign sample_stall = in_valid_reg && !out_free;

    assign key_valid = out_valid_reg;
    assign key_word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reload_reg <= akdr_pkg::HOLD_RELOAD_RESET;
        end
        else if (cfg_write)
        begin
            hold_reload_reg <= cfg_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!sample_stall)
        begin
            in_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && !sample_stall)
        begin
            in_word_reg <= sample_word;
        end
    end

    // classify and debounce
    always_comb
    begin
        code      = akdr_pkg::classify(in_word_reg.sample);
        // arm request takes effect before this sample is judged
        armed_now = armed_reg | in_word_reg.arm_repeat;
        new_key   = 1'b0;

        prev_code_next     = prev_code_reg;
        accepted_code_next = accepted_code_reg;
        hold_count_next    = hold_count_reg;
        armed_next         = armed_now;
        out_word_next      = out_word_reg;

        if (code == prev_code_reg)
        begin
            if (code == accepted_code_reg)
            begin
                if (armed_now)
                begin
                    if (hold_count_reg != 8'd0)
                    begin
                        // still counting down toward repeat
                        out_word_next.key_hit = 1'b0;
                        hold_count_next       = hold_count_reg - 8'd1;
                    end
                    else
                    begin
                        // repeating: hit on every held sample
                        out_word_next.key_code = code;
                        out_word_next.key_hit  = 1'b1;
                    end
                end
                else
                begin
                    out_word_next.key_hit = 1'b0;
                    hold_count_next       = hold_reload_reg;
                end
            end
            else
            begin
                // stable code differs from accepted key, release included
                new_key                = 1'b1;
                accepted_code_next     = code;
                out_word_next.key_code = code;
                out_word_next.key_hit  = 1'b1;
                hold_count_next        = hold_reload_reg;
                armed_next             = 1'b0;
            end
        end
        else
        begin
            // bouncing: report no key until two samples agree
            prev_code_next         = code;
            out_word_next.key_code = akdr_pkg::KEY_NONE;
            out_word_next.key_hit  = 1'b0;
            hold_count_next        = hold_reload_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_code_reg         <= akdr_pkg::KEY_NONE;
            accepted_code_reg     <= akdr_pkg::KEY_NONE;
            hold_count_reg        <= akdr_pkg::HOLD_COUNT_RESET;
            armed_reg             <= 1'b0;
            out_word_reg.key_code <= akdr_pkg::KEY_NONE;
            out_word_reg.key_hit  <= 1'b0;
        end
        else if (process)
        begin
            prev_code_reg     <= prev_code_next;
            accepted_code_reg <= accepted_code_next;
            hold_count_reg    <= hold_count_next;
            armed_reg         <= armed_next;
            out_word_reg      <= out_word_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // checks
    `AKDR_ASSERT_NOW(a_code_range, clk, rst_n, key_valid,
        key_word.key_code <= akdr_pkg::KEY_MODE, "key code out of range")
    `AKDR_ASSERT_NOW(a_stall_cause, clk, rst_n, sample_stall,
        key_valid && key_stall && in_valid_reg, "sample stall without full pipe")
    `AKDR_ASSERT_NXT(a_new_key_disarms, clk, rst_n, process && new_key,
        !armed_reg && key_word.key_hit, "new key did not disarm repeat")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad decoder testbench
// feeds ladder readings through the debounce and repeat core, first from a
// short table of hand-picked words, then as random key presses with random
// hold lengths, noise and bounces, under several hold reload settings; every
// key word that comes back is checked against the table's typed word or an
// in-bench model of the debounce, release and auto-repeat behavior
// ----------------------------------------------------------------------------
module tb_top;

    import akdr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_WORDS = 200;
    localparam int IDLE_PCT    = 36;
    localparam int HOLD_CYCLES = 60;

    // table rows either offer a sample word or load the hold reload register
    typedef enum logic {ROW_SAMPLE, ROW_RELOAD} row_kind_e;

    typedef struct packed {
        row_kind_e  kind;
        logic [9:0] sample;
        logic       arm;
        logic [7:0] reload;
        logic       known;
        logic [2:0] code;
        logic       hit;
    } plan_row_t;

    // a hand-typed key word travels with its sample word to the accept point
    typedef struct packed {
        logic      known;
        out_word_t word;
    } typed_key_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      sample_valid = 1'b0;
    logic      sample_stall;
    in_word_t  sample_word = '0;
    logic      key_valid;
    logic      key_stall = 1'b0;
    out_word_t key_word;
    logic      cfg_write = 1'b0;
    logic [7:0] cfg_data = '0;

    // model state of the debounce and repeat logic
    logic [7:0] reload     = HOLD_RELOAD_RESET;
    logic [2:0] last_code  = KEY_NONE;
    logic [2:0] held_code  = KEY_NONE;
    logic [2:0] shown_code = KEY_NONE;
    logic [7:0] countdown  = HOLD_COUNT_RESET;
    logic       armed      = 1'b0;
    logic       hit        = 1'b0;

    out_word_t  key_words_due[$];
    typed_key_t typed_keys[$];

    int errors = 0;
    int cycles = 0;
    bit calm = 1'b0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    // directed words: every window edge, every key, release, hold without arm,
    // arm during a change, zero reload repeating on the first held word
    plan_row_t plan [0:25] = '{
        '{ROW_SAMPLE, 10'h000, 1'b0, 8'd0,   1'b1, KEY_NONE,          1'b0},
        '{ROW_SAMPLE, 10'h02f, 1'b0, 8'd0,   1'b1, KEY_BRIGHT_DOWN,   1'b1},
        '{ROW_SAMPLE, 10'h030, 1'b0, 8'd0,   1'b1, KEY_NONE,          1'b0},
        '{ROW_SAMPLE, 10'h0a0, 1'b0, 8'd0,   1'b1, KEY_NONE,          1'b1},
        '{ROW_SAMPLE, 10'h0a1, 1'b0, 8'd0,   1'b1, KEY_NONE,          1'b0},
        '{ROW_SAMPLE, 10'h11f, 1'b0, 8'd0,   1'b1, KEY_BRIGHT_UP,     1'b1},
        '{ROW_SAMPLE, 10'h11f, 1'b0, 8'd0,   1'b1, KEY_BRIGHT_UP,     1'b0},
        '{ROW_SAMPLE, 10'h1f1, 1'b0, 8'd0,   1'b1, KEY_NONE,          1'b0},
        '{ROW_SAMPLE, 10'h22f, 1'b0, 8'd0,   1'b1, KEY_CONTRAST_UP,   1'b1},
        '{ROW_SAMPLE, 10'h2d1, 1'b0, 8'd0,   1'b1, KEY_NONE,          1'b0},
        '{ROW_SAMPLE, 10'h31f, 1'b0, 8'd0,   1'b1, KEY_CONTRAST_DOWN, 1'b1},
        '{ROW_SAMPLE, 10'h351, 1'b0, 8'd0,   1'b1, KEY_NONE,          1'b0},
        '{ROW_SAMPLE, 10'h37f, 1'b0, 8'd0,   1'b1, KEY_MODE,          1'b1},
        '{ROW_SAMPLE, 10'h380, 1'b0, 8'd0,   1'b1, KEY_NONE,          1'b0},
        '{ROW_SAMPLE, 10'h3ff, 1'b0, 8'd0,   1'b1, KEY_NONE,          1'b1},
        '{ROW_SAMPLE, 10'h3ff, 1'b1, 8'd0,   1'b0, KEY_NONE,          1'b0},
        '{ROW_SAMPLE, 10'h3ff, 1'b0, 8'd0,   1'b0, KEY_NONE,          1'b0},
        '{ROW_RELOAD, 10'h000, 1'b0, 8'd0,   1'b0, KEY_NONE,          1'b0},
        '{ROW_SAMPLE, 10'h010, 1'b0, 8'd0,   1'b0, KEY_NONE,          1'b0},
        '{ROW_SAMPLE, 10'h010, 1'b0, 8'd0,   1'b0, KEY_NONE,          1'b0},
        '{ROW_SAMPLE, 10'h010, 1'b1, 8'd0,   1'b0, KEY_NONE,          1'b0},
        '{ROW_SAMPLE, 10'h010, 1'b0, 8'd0,   1'b0, KEY_NONE,          1'b0},
        '{ROW_SAMPLE, 10'h200, 1'b1, 8'd0,   1'b0, KEY_NONE,          1'b0},
        '{ROW_SAMPLE, 10'h200, 1'b0, 8'd0,   1'b0, KEY_NONE,          1'b0},
        '{ROW_SAMPLE, 10'h200, 1'b0, 8'd0,   1'b0, KEY_NONE,          1'b0},
        '{ROW_RELOAD, 10'h000, 1'b0, 8'd255, 1'b0, KEY_NONE,          1'b0}
    };

    // reload used by each random phase; phase four draws its own
    logic [7:0] reload_plan [0:6] = '{8'd0, 8'd3, 8'd255, 8'd1, 8'd0, 8'd2, 8'd255};

    analog_keypad_debounce_repeat_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_word  (sample_word),
        .key_valid    (key_valid),
        .key_stall    (key_stall),
        .key_word     (key_word),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ladder windows, open at both ends except the bottom one
    function automatic logic [2:0] ladder_key(input logic [9:0] s);
        if (s < WIN1_HI)
            return KEY_BRIGHT_DOWN;
        if (s > WIN2_LO && s < WIN2_HI)
            return KEY_BRIGHT_UP;
        if (s > WIN3_LO && s < WIN3_HI)
            return KEY_CONTRAST_UP;
        if (s > WIN4_LO && s < WIN4_HI)
            return KEY_CONTRAST_DOWN;
        if (s > WIN5_LO && s < WIN5_HI)
            return KEY_MODE;
        return KEY_NONE;
    endfunction

    // advances the debounce model by one sample word, returns the key word
    function automatic out_word_t decode_sample(input in_word_t w);
        logic [2:0] c;
        out_word_t  r;
        if (w.arm_repeat)
            armed = 1'b1;
        c = ladder_key(w.sample);
        if (c != last_code)
        begin
            // bounce: report none until two readings agree
            last_code  = c;
            shown_code = KEY_NONE;
            countdown  = reload;
            hit        = 1'b0;
        end
        else if (c != held_code)
        begin
            // new stable key, release included, gives a one-shot hit
            held_code  = c;
            shown_code = c;
            countdown  = reload;
            armed      = 1'b0;
            hit        = 1'b1;
        end
        else if (!armed)
        begin
            hit       = 1'b0;
            countdown = reload;
        end
        else if (countdown != 8'd0)
        begin
            hit       = 1'b0;
            countdown = countdown - 8'd1;
        end
        else
        begin
            // countdown spent: repeat on every held word
            shown_code = c;
            hit        = 1'b1;
        end
        r.key_code = shown_code;
        r.key_hit  = hit;
        return r;
    endfunction

    // a reading that lands inside the window of the given key
    function automatic logic [9:0] pick_sample(input logic [2:0] code);
        case (code)
            KEY_BRIGHT_DOWN:   return 10'($urandom_range(int'(WIN1_HI) - 1, 0));
            KEY_BRIGHT_UP:     return 10'($urandom_range(int'(WIN2_HI) - 1, int'(WIN2_LO) + 1));
            KEY_CONTRAST_UP:   return 10'($urandom_range(int'(WIN3_HI) - 1, int'(WIN3_LO) + 1));
            KEY_CONTRAST_DOWN: return 10'($urandom_range(int'(WIN4_HI) - 1, int'(WIN4_LO) + 1));
            KEY_MODE:          return 10'($urandom_range(int'(WIN5_HI) - 1, int'(WIN5_LO) + 1));
            default:
            begin
                // any gap between windows, bounds included
                case ($urandom_range(4, 0))
                    0:       return 10'($urandom_range(int'(WIN2_LO), int'(WIN1_HI)));
                    1:       return 10'($urandom_range(int'(WIN3_LO), int'(WIN2_HI)));
                    2:       return 10'($urandom_range(int'(WIN4_LO), int'(WIN3_HI)));
                    3:       return 10'($urandom_range(int'(WIN5_LO), int'(WIN4_HI)));
                    default: return 10'($urandom_range(1023, int'(WIN5_HI)));
                endcase
            end
        endcase
    endfunction

    task automatic report(input string what, input int due, input int seen);
        $display("mismatch %s: due %0d, seen %0d, cycle %0d", what, due, seen, cycles);
        errors++;
    endtask

    // offers one sample word, with random idle cycles ahead of it unless calm, and
    // returns at the edge that accepts it
    task automatic offer(input in_word_t w, input typed_key_t tag);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_word  <= w;
        typed_keys.push_back(tag);
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        sample_valid <= 1'b0;
        while (key_words_due.size() != 0 || typed_keys.size() != 0)
            @(posedge clk);
    endtask

    // reload is only written with the core empty and the input idle
    task automatic load_reload(input logic [7:0] v);
        drain();
        repeat (4) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // one press: the same key for len words, arm raised now and then
    task automatic press(input logic [2:0] code, input int len, input int arm_pct);
        in_word_t w;
        for (int i = 0; i < len; i++)
        begin
            w.sample     = pick_sample(code);
            w.arm_repeat = ($urandom_range(99) < arm_pct);
            offer(w, '0);
        end
    endtask

    // key side: random stalls, none while calm, and one long hold-off
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_left   = HOLD_CYCLES;
            hold_served = hold_requests;
        end
        if (hold_left > 0)
        begin
            key_stall <= 1'b1;
            hold_left--;
        end
        else
            key_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // accept point: reload writes, key word checks, and new expectations
    always @(posedge clk)
    begin
        out_word_t  want;
        typed_key_t tag;
        if (rst_n)
        begin
            if (cfg_write)
                reload = cfg_data;
            if (key_valid && !key_stall)
            begin
                if (key_words_due.size() == 0)
                    report("key word with none due", 0, int'(key_word));
                else
                begin
                    want = key_words_due.pop_front();
                    if (key_word.key_code != want.key_code)
                        report("key_code", int'(want.key_code), int'(key_word.key_code));
                    if (key_word.key_hit != want.key_hit)
                        report("key_hit", int'(want.key_hit), int'(key_word.key_hit));
                end
            end
            if (sample_valid && !sample_stall)
            begin
                tag  = typed_keys.pop_front();
                want = decode_sample(sample_word);
                key_words_due.push_back(tag.known ? tag.word : want);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        in_word_t   w;
        typed_key_t tag;
        logic [7:0] r;
        int         sent;
        int         len;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_RELOAD)
                load_reload(plan[i].reload);
            else
            begin
                w.sample           = plan[i].sample;
                w.arm_repeat       = plan[i].arm;
                tag.known          = plan[i].known;
                tag.word.key_code  = plan[i].code;
                tag.word.key_hit   = plan[i].hit;
                offer(w, tag);
            end
        end

        // random phases, each under its own reload
        for (int ph = 0; ph < 7; ph++)
        begin
            r = (ph == 4) ? 8'($urandom_range(254, 4)) : reload_plan[ph];
            load_reload(r);
            calm = (ph == 1);
            sent = 0;
            if (ph == 2)
            begin
                // long armed hold so a full-scale countdown runs out
                press(KEY_CONTRAST_UP, 2, 0);
                press(KEY_CONTRAST_UP, 270, 30);
                sent += 272;
            end
            while (sent < PHASE_WORDS)
            begin
                if (ph == 3 && sent > 20 && hold_requests == 0)
                    hold_requests++;
                len = $urandom_range(99);
                if (len < 15)
                begin
                    // noise across the full reading range
                    w.sample     = 10'($urandom_range(1023, 0));
                    w.arm_repeat = 1'($urandom_range(1, 0));
                    offer(w, '0);
                    sent++;
                end
                else if (len < 25)
                begin
                    // bounce: a single reading that never settles
                    press(3'($urandom_range(5, 0)), 1, 50);
                    sent++;
                end
                else
                begin
                    len = $urandom_range(12, 2);
                    press(3'($urandom_range(5, 0)), len, 20);
                    sent += len;
                end
            end
            calm = 1'b0;
        end

        drain();
        repeat (6) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== analog_keypad_debounce_repeat_core.f =====
+incdir+design
design/akdr_pkg.sv
design/analog_keypad_debounce_repeat_core.sv
test/tb_top.sv
